@@ rtl/tpq_pkg.sv @@
// Shared types, constants and register indexes for the touch press qualifier.
`default_nettype none

package tpq_pkg;

  localparam int unsigned PadCountDefault = 3;

  localparam int unsigned PadIdxW   = 2;
  localparam int unsigned ReadingW  = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 24;

  localparam logic [ReadingW-1:0] ThrMax = 16'hFFFF;

  localparam logic [15:0] LongTouchMsRst = 16'd1000;
  localparam logic [15:0] KeepWeightRst  = 16'd62259;
  localparam logic [15:0] LearnWeightRst = 16'd2294;
  localparam logic [15:0] CalibWeightRst = 16'd45875;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_TOUCH_MS = 2'd0,
    CFG_KEEP_WEIGHT   = 2'd1,
    CFG_LEARN_WEIGHT  = 2'd2,
    CFG_CALIB_WEIGHT  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_MEASURE   = 1'b0,
    REQ_CALIBRATE = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [15:0]        long_touch_ms;
    logic [WeightW-1:0] keep_weight;
    logic [WeightW-1:0] learn_weight;
    logic [WeightW-1:0] calib_weight;
  } cfg_t;

  typedef struct packed {
    logic [ReadingW-1:0] threshold;
    logic                held;
    logic                long_hold;
    logic [TimeW-1:0]    press_time;
  } pad_state_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [PadIdxW-1:0]  pad_index;
    logic [ReadingW-1:0] reading_sum;
    logic [TimeW-1:0]    now_ms;
  } in_item_t;

  typedef struct packed {
    logic                is_touched;
    logic                press_event;
    logic                long_start;
    logic                bright_toggle;
    logic                release_event;
    logic [ReadingW-1:0] threshold_now;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/tpq_cfg_regs.sv @@
// Configuration register file for the touch press qualifier.
`default_nettype none

module tpq_cfg_regs
  import tpq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LONG_TOUCH_MS: cfg_nxt.long_touch_ms = cfg_wdata;
        CFG_KEEP_WEIGHT:   cfg_nxt.keep_weight   = cfg_wdata;
        CFG_LEARN_WEIGHT:  cfg_nxt.learn_weight  = cfg_wdata;
        CFG_CALIB_WEIGHT:  cfg_nxt.calib_weight  = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_touch_ms <= LongTouchMsRst;
      cfg_r.keep_weight   <= KeepWeightRst;
      cfg_r.learn_weight  <= LearnWeightRst;
      cfg_r.calib_weight  <= CalibWeightRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/tpq_datapath.sv @@
// Threshold update, touch decision and event logic for one request.
`default_nettype none

module tpq_datapath
  import tpq_pkg::*;
(
  input  wire in_item_t   item,
  input  wire logic       pad_ok,
  input  wire cfg_t       cfg,
  input  wire pad_state_t cur,
  output pad_state_t      nxt,
  output out_item_t       res
);

  logic [2*ReadingW-1:0] calib_prod;
  logic [2*ReadingW-1:0] keep_prod;
  logic [2*ReadingW-1:0] learn_prod;
  logic [2*ReadingW:0]   acc;
  logic [ReadingW:0]     acc_hi;
  logic [ReadingW-1:0]   track_thr;
  logic [TimeW-1:0]      elapsed;
  logic                  is_long;
  logic                  touched;

  assign calib_prod = item.reading_sum * cfg.calib_weight;
  assign keep_prod  = cur.threshold * cfg.keep_weight;
  assign learn_prod = item.reading_sum * cfg.learn_weight;
  assign acc        = {1'b0, keep_prod} + {1'b0, learn_prod};
  assign acc_hi     = acc[2*ReadingW:ReadingW];
  // The weighted sum can exceed 16 bits when the weights add past one.
  assign track_thr  = acc_hi[ReadingW] ? ThrMax : acc_hi[ReadingW-1:0];
  assign touched    = item.reading_sum < track_thr;
  assign elapsed    = item.now_ms - cur.press_time;
  assign is_long    = elapsed > {{(TimeW-16){1'b0}}, cfg.long_touch_ms};

  always_comb begin
    nxt = cur;
    res = '0;
    if (pad_ok) begin
      if (item.req_type == REQ_CALIBRATE) begin
        nxt.threshold = calib_prod[2*ReadingW-1:ReadingW];
      end else begin
        nxt.threshold  = track_thr;
        res.is_touched = touched;
        if (touched) begin
          if (cur.held) begin
            if (is_long) begin
              nxt.long_hold     = 1'b1;
              res.long_start    = !cur.long_hold;
              res.bright_toggle = 1'b1;
            end
          end else begin
            res.press_event = 1'b1;
            nxt.held        = 1'b1;
            nxt.press_time  = item.now_ms;
          end
        end else begin
          res.release_event = cur.held;
          nxt.held          = 1'b0;
          nxt.long_hold     = 1'b0;
        end
      end
      res.threshold_now = nxt.threshold;
    end
  end

endmodule

`default_nettype wire

@@ rtl/touch_press_qualifier_top.sv @@
// Top level of the touch press qualifier: input register, pad state and result register.
//
// Usage: each request on the in_ stream carries one summed pad reading with a
// millisecond timestamp; in_tuser says whether it measures or calibrates. Every
// request yields exactly one result on the out_ stream with the touch flag,
// the press, long-start, brightness-toggle and release events, and the pad
// threshold after the update.
// Pipeline: an accepted request is captured in the input register; its result then
// moves to the result register, which drives out_tvalid. Throughput is one request per
// cycle while out_tready allows; per-pad state is read and written as the result is
// registered, so consecutive requests to the same pad see each other's updates.
// Stalls: while out_tready is low the result register holds, the input
// register still takes one more request, and in_tready then drops until
// the result is taken.
// Reset (rst_n low, synchronous): all pad thresholds go to 65535, held and long flags
// clear, configuration returns to its defaults, both stages empty. The user writes
// configuration via cfg_we/cfg_index/cfg_wdata only while idle; the block does not check.
`default_nettype none

module touch_press_qualifier_top
  import tpq_pkg::*;
#(
  parameter int unsigned PAD_COUNT = PadCountDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // [1:0] pad_index, [17:2] reading_sum, [49:18] now_ms, [55:50] zero
  input  wire logic [InDataW-1:0]  in_tdata,
  // [0] req_type
  input  wire logic                in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [0] is_touched, [1] press_event, [2] long_start, [3] bright_toggle,
  // [4] release_event, [20:5] threshold_now, [23:21] zero
  output logic [OutDataW-1:0]      out_tdata,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  localparam int unsigned PadAw = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  cfg_t       cfg;
  in_item_t   in_r;
  logic       in_vld_r;
  out_item_t  out_r;
  logic       out_vld_r;
  logic       advance;
  logic       pad_ok;
  logic [PadAw-1:0] pad_sel;
  pad_state_t cur_state;
  pad_state_t nxt_state;
  out_item_t  res;

  logic [ReadingW-1:0] thr_r        [PAD_COUNT];
  logic                held_r       [PAD_COUNT];
  logic                long_r       [PAD_COUNT];
  logic [TimeW-1:0]    press_time_r [PAD_COUNT];

  tpq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r.req_type    <= req_type_t'(in_tuser);
      in_r.pad_index   <= in_tdata[1:0];
      in_r.reading_sum <= in_tdata[17:2];
      in_r.now_ms      <= in_tdata[49:18];
    end
  end

  assign pad_ok  = 32'(in_r.pad_index) < PAD_COUNT;
  assign pad_sel = PadAw'(in_r.pad_index);

  always_comb begin
    cur_state = '0;
    if (pad_ok) begin
      cur_state.threshold  = thr_r[pad_sel];
      cur_state.held       = held_r[pad_sel];
      cur_state.long_hold  = long_r[pad_sel];
      cur_state.press_time = press_time_r[pad_sel];
    end
  end

  tpq_datapath u_dp (
    .item   (in_r),
    .pad_ok (pad_ok),
    .cfg    (cfg),
    .cur    (cur_state),
    .nxt    (nxt_state),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        thr_r[p]        <= ThrMax;
        held_r[p]       <= 1'b0;
        long_r[p]       <= 1'b0;
        press_time_r[p] <= '0;
      end
    end else if (advance && pad_ok) begin
      thr_r[pad_sel]        <= nxt_state.threshold;
      held_r[pad_sel]       <= nxt_state.held;
      long_r[pad_sel]       <= nxt_state.long_hold;
      press_time_r[pad_sel] <= nxt_state.press_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutDataW-21){1'b0}}, out_r.threshold_now, out_r.release_event,
                       out_r.bright_toggle, out_r.long_start, out_r.press_event,
                       out_r.is_touched};

endmodule

`default_nettype wire
